@@ hw/rtl/slri_pkg.sv @@
// shared types and defaults for the sorted insert/remove list
`timescale 1ns / 1ps

package slri_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int TAG_BITS_DEF = 32;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        t_opcode            opcode;
        logic signed [31:0] entry_score;
        logic [31:0]        entry_tag;
    } t_in_beat;

    typedef struct packed {
        t_status            status;
        logic [4:0]         entry_count;
        logic signed [31:0] head_score;
        logic [31:0]        head_tag;
        logic signed [31:0] tail_score;
        logic [31:0]        tail_tag;
    } t_out_beat;

    typedef struct packed {
        logic do_insert;
        logic do_remove;
    } t_cell_cmd;

endpackage

@@ hw/rtl/slri_cell.sv @@
// one slot of the sorted chain: holds an entry and shifts with its neighbors
`timescale 1ns / 1ps

module slri_cell #(
    parameter int TAG_BITS = slri_pkg::TAG_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  slri_pkg::t_cell_cmd     i_cmd,
    input  logic signed [31:0]      i_key_score,
    input  logic [TAG_BITS-1:0]     i_key_tag,
    input  logic                    i_left_lt,
    input  logic                    i_left_valid,
    input  logic signed [31:0]      i_left_score,
    input  logic [TAG_BITS-1:0]     i_left_tag,
    input  logic                    i_found_in,
    input  logic                    i_right_valid,
    input  logic signed [31:0]      i_right_score,
    input  logic [TAG_BITS-1:0]     i_right_tag,
    output logic                    o_lt,
    output logic                    o_found,
    output logic                    o_valid,
    output logic signed [31:0]      o_score,
    output logic [TAG_BITS-1:0]     o_tag
);
    import slri_pkg::*;

    logic                r_valid;
    logic signed [31:0]  r_score;
    logic [TAG_BITS-1:0] r_tag;
    logic                n_valid;
    logic signed [31:0]  n_score;
    logic [TAG_BITS-1:0] n_tag;
    logic                match;

    assign o_lt    = r_valid && (r_score < i_key_score);
    assign match   = r_valid && (r_score == i_key_score) && (r_tag == i_key_tag);
    assign o_found = i_found_in || match;
    assign o_valid = r_valid;
    assign o_score = r_score;
    assign o_tag   = r_tag;

    always_comb begin
        n_valid = r_valid;
        n_score = r_score;
        n_tag   = r_tag;
        if (i_cmd.do_insert && !o_lt) begin
            // first slot not below the key takes it, the rest shift right
            if (i_left_lt) begin
                n_valid = 1'b1;
                n_score = i_key_score;
                n_tag   = i_key_tag;
            end else begin
                n_valid = i_left_valid;
                n_score = i_left_score;
                n_tag   = i_left_tag;
            end
        end else if (i_cmd.do_remove && o_found) begin
            // from the first match on, pull from the right
            n_valid = i_right_valid;
            n_score = i_right_score;
            n_tag   = i_right_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_score <= n_score;
        r_tag   <= n_tag;
    end

endmodule

@@ hw/rtl/sorted_list_insert_remove.sv @@
// top level: sorted priority list built as a chain of slot cells
`timescale 1ns / 1ps

// Sorted list of up to CAPACITY entries (signed 32-bit score, TAG_BITS tag),
// ascending from head. Every slot compares itself with the incoming key in
// the same cycle and the whole chain shifts by one place, so an operation
// is applied at the edge it is accepted; its result beat is registered out
// once the result side is free. The block takes one operation per cycle as
// long as the result side does not stall; a stalled result holds back at
// most one further operation. Cycle time is set by the first-match prefix
// that ripples through all CAPACITY cells, plus the tail select by count.
module sorted_list_insert_remove #(
    parameter int CAPACITY = slri_pkg::CAPACITY_DEF,
    parameter int TAG_BITS = slri_pkg::TAG_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  slri_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output slri_pkg::t_out_beat o_out_data
);
    import slri_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    logic signed [31:0]  c_score [CAPACITY];
    logic [TAG_BITS-1:0] c_tag   [CAPACITY];
    logic [CAPACITY-1:0] c_valid;
    logic [CAPACITY-1:0] c_lt;
    logic [CAPACITY-1:0] c_found;

    logic [TAG_BITS-1:0] key_tag;
    t_cell_cmd           cmd;
    logic                in_acc;
    logic                full;
    logic                empty;
    logic                found;
    logic                out_free;
    logic                load;
    t_status             n_status;

    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic [CNT_W-1:0]    count_m1;
    logic [IDX_W-1:0]    tail_idx;
    logic                r_pend;
    t_status             r_status;
    logic                r_out_valid;
    t_out_beat           r_out;

    logic [4:0]          count5;
    logic [31:0]         head_tag32;
    logic [31:0]         tail_tag32;

    // tag width adaption on the way in and out
    if (TAG_BITS > 32) begin : g_tag_wide
        assign key_tag    = {{(TAG_BITS - 32){1'b0}}, i_in_data.entry_tag};
        assign head_tag32 = c_tag[0][31:0];
        assign tail_tag32 = c_tag[tail_idx][31:0];
    end else if (TAG_BITS == 32) begin : g_tag_same
        assign key_tag    = i_in_data.entry_tag;
        assign head_tag32 = c_tag[0];
        assign tail_tag32 = c_tag[tail_idx];
    end else begin : g_tag_narrow
        assign key_tag    = i_in_data.entry_tag[TAG_BITS-1:0];
        assign head_tag32 = {{(32 - TAG_BITS){1'b0}}, c_tag[0]};
        assign tail_tag32 = {{(32 - TAG_BITS){1'b0}}, c_tag[tail_idx]};
    end

    if (CNT_W > 5) begin : g_cnt_wide
        assign count5 = r_count[4:0];
    end else if (CNT_W == 5) begin : g_cnt_same
        assign count5 = r_count;
    end else begin : g_cnt_narrow
        assign count5 = {{(5 - CNT_W){1'b0}}, r_count};
    end

    assign full     = c_valid[CAPACITY-1];
    assign empty    = !c_valid[0];
    assign found    = c_found[CAPACITY-1];
    assign out_free = !r_out_valid || !i_out_stall;
    assign load     = r_pend && out_free;

    assign o_in_stall = r_pend && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign cmd.do_insert = in_acc && (i_in_data.opcode == OP_INSERT) && !full;
    assign cmd.do_remove = in_acc && (i_in_data.opcode == OP_REMOVE);

    assign count_m1 = r_count - CNT_W'(1);
    assign tail_idx = count_m1[IDX_W-1:0];

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic                left_lt;
        logic                left_valid;
        logic signed [31:0]  left_score;
        logic [TAG_BITS-1:0] left_tag;
        logic                found_in;
        logic                right_valid;
        logic signed [31:0]  right_score;
        logic [TAG_BITS-1:0] right_tag;

        if (gi == 0) begin : g_head
            // nothing lies left of the head, so it always sees a smaller score
            assign left_lt    = 1'b1;
            assign left_valid = 1'b0;
            assign left_score = '0;
            assign left_tag   = '0;
            assign found_in   = 1'b0;
        end else begin : g_inner
            assign left_lt    = c_lt[gi-1];
            assign left_valid = c_valid[gi-1];
            assign left_score = c_score[gi-1];
            assign left_tag   = c_tag[gi-1];
            assign found_in   = c_found[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_last
            assign right_valid = 1'b0;
            assign right_score = '0;
            assign right_tag   = '0;
        end else begin : g_body
            assign right_valid = c_valid[gi+1];
            assign right_score = c_score[gi+1];
            assign right_tag   = c_tag[gi+1];
        end

        slri_cell #(
            .TAG_BITS(TAG_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (cmd),
            .i_key_score   (i_in_data.entry_score),
            .i_key_tag     (key_tag),
            .i_left_lt     (left_lt),
            .i_left_valid  (left_valid),
            .i_left_score  (left_score),
            .i_left_tag    (left_tag),
            .i_found_in    (found_in),
            .i_right_valid (right_valid),
            .i_right_score (right_score),
            .i_right_tag   (right_tag),
            .o_lt          (c_lt[gi]),
            .o_found       (c_found[gi]),
            .o_valid       (c_valid[gi]),
            .o_score       (c_score[gi]),
            .o_tag         (c_tag[gi])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_DONE;
        case (i_in_data.opcode)
            OP_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else if (!found) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_count <= n_count;
            end
            if (in_acc) begin
                r_pend <= 1'b1;
            end else if (load) begin
                r_pend <= 1'b0;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_status <= n_status;
        end
        // cells hold the state left by the pending beat until this edge
        if (load) begin
            r_out.status      <= r_status;
            r_out.entry_count <= count5;
            r_out.head_score  <= c_valid[0] ? c_score[0] : 32'sd0;
            r_out.head_tag    <= c_valid[0] ? head_tag32 : 32'd0;
            r_out.tail_score  <= (r_count != '0) ? c_score[tail_idx] : 32'sd0;
            r_out.tail_tag    <= (r_count != '0) ? tail_tag32 : 32'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(c_valid) == r_count)
        else $error("entry count differs from occupied cells");

    a_cells_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((c_valid + CAPACITY'(1)) & c_valid) == '0)
        else $error("occupied cells are not packed toward the head");

    a_full_insert_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in_data.opcode == OP_INSERT) && full |=> $stable(c_valid))
        else $error("refused insert changed the list");

    a_pend_reaches_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> o_out_valid)
        else $error("pending result did not reach the output");
`endif

endmodule

@@ sim/tb_top.sv @@
// testbench for the sorted insert/remove list: random and directed beats, scoreboard check
`timescale 1ns / 1ps

module tb_top;
    import slri_pkg::*;

    localparam int HOLD_LEN   = 80;
    localparam int IDLE_LIMIT = 2000;

    // ordered-list predictor plus queue of expected result beats
    class list_scoreboard;
        logic signed [31:0] slot_score [CAPACITY_DEF];
        logic [31:0]        slot_tag [CAPACITY_DEF];
        int                 held;
        t_out_beat          expected_beats[$];
        int                 errors;
        int                 status_seen[4];

        function new();
            held   = 0;
            errors = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void note_op(t_in_beat b);
            t_out_beat          exp_beat;
            logic signed [31:0] sc;
            logic [31:0]        tg;
            int                 pos;
            t_status            st;
            sc  = b.entry_score;
            tg  = b.entry_tag;
            pos = 0;
            st  = ST_DONE;
            if (b.opcode == OP_INSERT) begin
                if (held >= CAPACITY_DEF) begin
                    st = ST_FULL;
                end else begin
                    // new entry goes ahead of every equal score
                    while (pos < held && slot_score[pos] < sc) pos++;
                    for (int k = held; k > pos; k--) begin
                        slot_score[k] = slot_score[k-1];
                        slot_tag[k]   = slot_tag[k-1];
                    end
                    slot_score[pos] = sc;
                    slot_tag[pos]   = tg;
                    held++;
                end
            end else begin
                while (pos < held && !(slot_score[pos] == sc && slot_tag[pos] == tg)) pos++;
                if (held == 0) begin
                    st = ST_EMPTY;
                end else if (pos == held) begin
                    st = ST_NOT_FOUND;
                end else begin
                    for (int k = pos; k + 1 < held; k++) begin
                        slot_score[k] = slot_score[k+1];
                        slot_tag[k]   = slot_tag[k+1];
                    end
                    held--;
                end
            end
            exp_beat             = '0;
            exp_beat.status      = st;
            exp_beat.entry_count = 5'(held);
            if (held > 0) begin
                exp_beat.head_score = slot_score[0];
                exp_beat.head_tag   = slot_tag[0];
                exp_beat.tail_score = slot_score[held-1];
                exp_beat.tail_tag   = slot_tag[held-1];
            end
            status_seen[st]++;
            expected_beats.push_back(exp_beat);
        endfunction

        function void check_beat(t_out_beat got);
            t_out_beat want;
            if (expected_beats.size() == 0) begin
                $error("result beat with nothing expected: %h", got);
                errors++;
                return;
            end
            want = expected_beats.pop_front();
            if (got.status != want.status) begin
                $error("status expected %0d actual %0d", want.status, got.status);
                errors++;
            end
            if (got.entry_count != want.entry_count) begin
                $error("entry_count expected %0d actual %0d", want.entry_count, got.entry_count);
                errors++;
            end
            if (got.head_score !== want.head_score) begin
                $error("head_score expected %0d actual %0d", want.head_score, got.head_score);
                errors++;
            end
            if (got.head_tag !== want.head_tag) begin
                $error("head_tag expected %h actual %h", want.head_tag, got.head_tag);
                errors++;
            end
            if (got.tail_score !== want.tail_score) begin
                $error("tail_score expected %0d actual %0d", want.tail_score, got.tail_score);
                errors++;
            end
            if (got.tail_tag !== want.tail_tag) begin
                $error("tail_tag expected %h actual %h", want.tail_tag, got.tail_tag);
                errors++;
            end
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_beat  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_beat o_out_data;

    list_scoreboard sb;

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_start;
    int  idle_cycles;

    logic signed [31:0] pool_score[$];
    logic [31:0]        pool_tag[$];

    sorted_list_insert_remove dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver: random stall, or a long hold-off counted here
    initial begin
        int hold_left;
        hold_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_start) begin
                hold_start = 1'b0;
                hold_left  = HOLD_LEN;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // monitor: result beats checked before the same edge's input beat is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) sb.check_beat(o_out_data);
            if (i_in_valid && !o_in_stall) sb.note_op(i_in_data);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic t_in_beat make_op(t_opcode op, logic signed [31:0] sc, logic [31:0] tg);
        t_in_beat b;
        b.opcode      = op;
        b.entry_score = sc;
        b.entry_tag   = tg;
        return b;
    endfunction

    function automatic logic signed [31:0] rand_score();
        int sel;
        int v;
        sel = $urandom_range(99);
        if (sel < 50) begin
            v = int'($urandom_range(8)) - 4;
            return v;
        end
        if (sel < 60) begin
            case ($urandom_range(3))
                0: return 32'sh8000_0000;
                1: return 32'sh7FFF_FFFF;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [31:0] rand_tag();
        if ($urandom_range(99) < 40) return $urandom_range(3);
        return $urandom;
    endfunction

    task automatic send_op(input t_in_beat b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        // let the monitor note the last accepted beat first
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // mostly inserts in fill bursts, mostly matching removes in drain bursts
    task automatic run_phase(input int n_items, input bit with_hold);
        bit                 fill_mode;
        int                 burst_left;
        int                 idx;
        logic signed [31:0] sc;
        logic [31:0]        tg;
        fill_mode  = 1'b1;
        burst_left = $urandom_range(15, 40);
        for (int n = 0; n < n_items; n++) begin
            if (with_hold && n == 30) hold_start = 1'b1;
            if (burst_left == 0) begin
                fill_mode  = !fill_mode;
                burst_left = $urandom_range(15, 40);
            end
            burst_left--;
            if ($urandom_range(99) < (fill_mode ? 80 : 20)) begin
                sc = rand_score();
                tg = rand_tag();
                pool_score.push_back(sc);
                pool_tag.push_back(tg);
                if (pool_score.size() > 32) begin
                    void'(pool_score.pop_front());
                    void'(pool_tag.pop_front());
                end
                send_op(make_op(OP_INSERT, sc, tg));
            end else if (pool_score.size() > 0 && $urandom_range(99) < 75) begin
                idx = $urandom_range(pool_score.size() - 1);
                sc  = pool_score[idx];
                tg  = pool_tag[idx];
                if ($urandom_range(9) == 0) begin
                    tg = tg ^ 32'h1;
                end else begin
                    pool_score.delete(idx);
                    pool_tag.delete(idx);
                end
                send_op(make_op(OP_REMOVE, sc, tg));
            end else begin
                send_op(make_op(OP_REMOVE, rand_score(), rand_tag()));
            end
        end
        wait_drained();
    endtask

    initial begin
        sb             = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_start     = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty, no match on a single entry, extremes, ties, full
        send_op(make_op(OP_REMOVE, 32'sd0, 32'h0));
        send_op(make_op(OP_INSERT, 32'sd0, 32'hFFFF_FFFF));
        send_op(make_op(OP_REMOVE, 32'sd0, 32'h0));
        send_op(make_op(OP_REMOVE, 32'sd0, 32'hFFFF_FFFF));
        send_op(make_op(OP_INSERT, 32'sh7FFF_FFFF, 32'h0));
        send_op(make_op(OP_INSERT, 32'sh8000_0000, 32'h1));
        send_op(make_op(OP_INSERT, 32'sh8000_0000, 32'h2));
        send_op(make_op(OP_INSERT, 32'sh7FFF_FFFF, 32'h3));
        send_op(make_op(OP_INSERT, -32'sd1, 32'hAAAA_AAAA));
        send_op(make_op(OP_REMOVE, 32'sh8000_0000, 32'h1));
        for (int k = 0; k < 12; k++) begin
            send_op(make_op(OP_INSERT, k * 1000 - 5000, 32'h5555_0000 + k));
        end
        send_op(make_op(OP_INSERT, 32'sd5, 32'h5));
        send_op(make_op(OP_REMOVE, 32'sh7FFF_FFFF, 32'h3));
        wait_drained();

        run_phase(125, 1'b1);
        send_idle_pct = 65;
        run_phase(125, 1'b0);
        send_idle_pct  = 0;
        recv_stall_pct = 65;
        run_phase(125, 1'b0);
        send_idle_pct  = 9;
        recv_stall_pct = 9;
        run_phase(125, 1'b0);

        repeat (10) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d expected result beats never arrived", sb.pending());
            sb.errors++;
        end
        $display("checked %0d done, %0d not found, %0d empty, %0d full results",
                 sb.status_seen[ST_DONE], sb.status_seen[ST_NOT_FOUND],
                 sb.status_seen[ST_EMPTY], sb.status_seen[ST_FULL]);
        $display("idle mixes: none, sender, receiver, both; one long result hold-off");
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
